// ===== src/record_table_field_match_assert.svh =====
// ----------------------------------------------------------------------------
// record table field match: assertion macros
// shared check forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef RECORD_TABLE_FIELD_MATCH_ASSERT_SVH
`define RECORD_TABLE_FIELD_MATCH_ASSERT_SVH

// same-cycle implication
`define RTFM_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("record_table_field_match: same-cycle check failed");

// next-cycle implication
`define RTFM_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("record_table_field_match: next-cycle check failed");

`endif

// ===== src/rtfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtfm_pkg
// sizes, codes, beat and control types for the record table field match
// ----------------------------------------------------------------------------
`default_nettype none

package rtfm_pkg;

  localparam int ROWS        = 64;
  localparam int FIELD_CHARS = 15;
  localparam int FIELDS      = 3;
  localparam int ROW_CHARS   = FIELDS * FIELD_CHARS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int CNT_W       = $clog2(ROWS + 1);
  localparam int POS_W       = $clog2(FIELD_CHARS + 1);
  localparam int CHAR_IDX_W  = $clog2(ROW_CHARS);
  localparam int TXT_W       = 2;
  localparam logic [7:0] PAD_CHAR = 8'h20;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_FIND = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_MATCH     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_FULL      = 3'd4,
    ST_READ      = 3'd5
  } status_t;

  typedef logic [FIELD_CHARS-1:0][7:0]             field_t;
  typedef logic [FIELDS-1:0][FIELD_CHARS-1:0][7:0] row_word_t;
  typedef logic [ROW_CHARS-1:0][7:0]               row_flat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic       end_of_text;
    logic [5:0] row_select;
    logic [5:0] char_position;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] row_index;
    logic [7:0] char_out;
    logic       last_result;
  } out_beat_t;

  typedef struct packed {
    logic accept;
    logic read_res;
    logic scan_adv;
    logic put;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_read;
    logic in_scan;
    logic in_res;
    logic match;
    logic pend_valid;
    logic last_row;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/rtfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtfm_ctrl
// sequencer: item intake, read wait, row scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module rtfm_ctrl
  import rtfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  input  wire dp_sts_t   sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RDW  = 4'b0010,
    S_SCAN = 4'b0100,
    S_PUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  // a second match cannot retire the held one until the output frees up
  assign stall = sts.match && sts.pend_valid && !sts.out_free;

  assign item_ready   = (state == S_IDLE);
  assign cmd.accept   = item_valid && (state == S_IDLE);
  assign cmd.read_res = (state == S_RDW);
  assign cmd.scan_adv = (state == S_SCAN) && !stall;
  assign cmd.put      = (state == S_PUT) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          if (sts.in_read) begin
            state_next = S_RDW;
          end else if (sts.in_scan) begin
            state_next = S_SCAN;
          end else if (sts.in_res) begin
            state_next = S_PUT;
          end
        end
      end
      S_RDW: begin
        state_next = S_PUT;
      end
      S_SCAN: begin
        if (cmd.scan_adv && sts.last_row) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (cmd.put) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rtfm_dp.sv =====
// ----------------------------------------------------------------------------
// rtfm_dp
// record and key buffers, row store, field compare and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rtfm_dp
  import rtfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_beat_t  item,
  input  wire ctrl_cmd_t cmd,
  output dp_sts_t        sts,
  output out_beat_t      result,
  output logic           result_valid,
  input  wire logic      result_ready
);

  // row store, one whole record per word
  row_word_t mem [ROWS];

  // record assembly and key
  row_word_t              row_buf;
  row_word_t              row_buf_next;
  field_t                 key_buf;
  field_t                 key_buf_next;
  logic [CNT_W-1:0]       row_count;
  logic [TXT_W-1:0]       text_number;
  logic [POS_W-1:0]       text_position;
  logic                   too_long;
  logic [POS_W-1:0]       key_pos;
  logic                   key_too_long;

  // read and scan
  row_word_t              rd_data;
  row_flat_t              rd_flat;
  logic                   rd_en;
  logic [ROW_W-1:0]       rd_addr;
  logic [5:0]             rd_row;
  logic [CHAR_IDX_W-1:0]  rd_pos;
  logic                   rd_ok;
  logic [ROW_W-1:0]       scan_row;
  logic [ROW_W-1:0]       pend_row;
  logic                   pend_valid;

  // results
  out_beat_t              res;
  out_beat_t              imm_res;
  out_beat_t              final_res;
  out_beat_t              out_data;
  logic                   out_valid;
  logic                   load_pend;

  logic                   is_add;
  logic                   is_find;
  logic                   is_read;
  logic                   add_store;
  logic [POS_W-1:0]       tpos_inc;
  logic                   too_long_now;
  logic                   room;
  logic                   rec_end;
  logic                   commit;
  logic                   key_store;
  logic [POS_W-1:0]       kpos_inc;
  logic                   key_tl_now;
  logic                   find_end;
  logic                   in_scan;
  logic                   match;
  logic                   last_row;
  logic [7:0]             rd_char;

  assign is_add  = (item.mode == MODE_ADD);
  assign is_find = (item.mode == MODE_FIND);
  assign is_read = (item.mode == MODE_READ);

  assign add_store    = (text_position < POS_W'(FIELD_CHARS));
  assign tpos_inc     = add_store ? text_position + POS_W'(1) : text_position;
  assign too_long_now = too_long || !add_store;
  assign room         = (row_count < CNT_W'(ROWS));
  assign rec_end      = is_add && item.end_of_text && (text_number == TXT_W'(2));
  assign commit       = cmd.accept && rec_end && !too_long_now && room;

  assign key_store  = (key_pos < POS_W'(FIELD_CHARS));
  assign kpos_inc   = key_store ? key_pos + POS_W'(1) : key_pos;
  assign key_tl_now = key_too_long || !key_store;
  assign find_end   = is_find && item.end_of_text;
  assign in_scan    = find_end && !key_tl_now && (row_count != '0);

  // current character into its slot, spaces behind the text end
  always_comb begin
    row_buf_next = row_buf;
    for (int f = 0; f < FIELDS; f++) begin
      for (int p = 0; p < FIELD_CHARS; p++) begin
        if (text_number == TXT_W'(f)) begin
          if (add_store && (POS_W'(p) == text_position)) begin
            row_buf_next[f][p] = item.char_code;
          end else if (item.end_of_text && (POS_W'(p) >= tpos_inc)) begin
            row_buf_next[f][p] = PAD_CHAR;
          end
        end
      end
    end
  end

  always_comb begin
    key_buf_next = key_buf;
    for (int p = 0; p < FIELD_CHARS; p++) begin
      if (key_store && (POS_W'(p) == key_pos)) begin
        key_buf_next[p] = item.char_code;
      end else if (item.end_of_text && (POS_W'(p) >= kpos_inc)) begin
        key_buf_next[p] = PAD_CHAR;
      end
    end
  end

  always_comb begin
    imm_res = '0;
    imm_res.last_result = 1'b1;
    if (rec_end) begin
      if (too_long_now) begin
        imm_res.status = ST_TOO_LONG;
      end else if (!room) begin
        imm_res.status = ST_FULL;
      end else begin
        imm_res.status    = ST_ADDED;
        imm_res.row_index = 6'(row_count);
      end
    end else if (key_tl_now) begin
      imm_res.status = ST_TOO_LONG;
    end else begin
      imm_res.status = ST_NOT_FOUND;
    end
  end

  assign match    = (rd_data[0] == key_buf) || (rd_data[1] == key_buf) ||
                    (rd_data[2] == key_buf);
  assign last_row = ((CNT_W'(scan_row) + CNT_W'(1)) == row_count);

  // the held match is final unless a later row matches
  always_comb begin
    final_res = '0;
    final_res.last_result = 1'b1;
    if (match) begin
      final_res.status    = ST_MATCH;
      final_res.row_index = 6'(scan_row);
    end else if (pend_valid) begin
      final_res.status    = ST_MATCH;
      final_res.row_index = 6'(pend_row);
    end else begin
      final_res.status = ST_NOT_FOUND;
    end
  end

  assign rd_flat = row_flat_t'(rd_data);
  assign rd_char = rd_ok ? rd_flat[rd_pos] : 8'd0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_row + ROW_W'(1);
    if (cmd.accept && is_read) begin
      rd_en   = 1'b1;
      rd_addr = item.row_select[ROW_W-1:0];
    end else if (cmd.accept && in_scan) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.scan_adv && !last_row) begin
      rd_en = 1'b1;
    end
  end

  assign load_pend = cmd.scan_adv && match && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      text_number   <= '0;
      text_position <= '0;
      too_long      <= 1'b0;
      key_pos       <= '0;
      key_too_long  <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (item.mode)
          MODE_ADD: begin
            too_long <= rec_end ? 1'b0 : too_long_now;
            if (item.end_of_text) begin
              text_position <= '0;
              text_number   <= rec_end ? '0 : text_number + TXT_W'(1);
            end else begin
              text_position <= tpos_inc;
            end
            if (commit) begin
              row_count <= row_count + CNT_W'(1);
            end
          end
          MODE_FIND: begin
            key_pos      <= item.end_of_text ? '0 : kpos_inc;
            key_too_long <= item.end_of_text ? 1'b0 : key_tl_now;
            pend_valid   <= 1'b0;
          end
          default: begin
          end
        endcase
      end else if (cmd.scan_adv && match) begin
        pend_valid <= 1'b1;
      end
      if (cmd.put || load_pend) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_add) begin
      row_buf <= row_buf_next;
    end
    if (cmd.accept && is_find) begin
      key_buf <= key_buf_next;
    end
    if (commit) begin
      mem[row_count[ROW_W-1:0]] <= row_buf_next;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.accept && is_read) begin
      rd_row <= item.row_select;
      rd_pos <= CHAR_IDX_W'(item.char_position);
      rd_ok  <= (CNT_W'(item.row_select) < row_count) &&
                (item.char_position < 6'(ROW_CHARS));
    end
    if (cmd.accept && in_scan) begin
      scan_row <= '0;
    end else if (cmd.scan_adv) begin
      scan_row <= scan_row + ROW_W'(1);
    end
    if (cmd.scan_adv && match) begin
      pend_row <= scan_row;
    end
    if (cmd.accept) begin
      res <= imm_res;
    end else if (cmd.read_res) begin
      res.status      <= ST_READ;
      res.row_index   <= rd_row;
      res.char_out    <= rd_char;
      res.last_result <= 1'b1;
    end else if (cmd.scan_adv && last_row) begin
      res <= final_res;
    end
    if (cmd.put) begin
      out_data <= res;
    end else if (load_pend) begin
      out_data.status      <= ST_MATCH;
      out_data.row_index   <= 6'(pend_row);
      out_data.char_out    <= 8'd0;
      out_data.last_result <= 1'b0;
    end
  end

  assign sts.in_read    = is_read;
  assign sts.in_scan    = in_scan;
  assign sts.in_res     = rec_end || (find_end && !in_scan);
  assign sts.match      = match;
  assign sts.pend_valid = pend_valid;
  assign sts.last_row   = last_row;
  assign sts.out_free   = !out_valid || result_ready;

  assign result       = out_data;
  assign result_valid = out_valid;

endmodule

`default_nettype wire

// ===== src/record_table_field_match.sv =====
// add and find characters with no result are accepted back to back
// record ends and key errors go via res to the output register, reads via rd_data first
// a find walks committed rows one row word per cycle, may stall on a full output
// a match waits in a holding register until a later row matches or the scan ends
// synchronous reset clears counters, flags and the sequencer; row store is not cleared,
// only committed rows reach the output, so no clearing pass runs after reset
// ----------------------------------------------------------------------------
// record_table_field_match
// table of three-field records with add, field-match find and character read
// ----------------------------------------------------------------------------
`default_nettype none

`include "record_table_field_match_assert.svh"

module record_table_field_match
  import rtfm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_beat_t item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_beat_t     result
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  rtfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rtfm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // only match beats may continue a find; anything else closes its item
  `RTFM_ASSERT_IMP(a_nonlast_is_match, result_valid && !result.last_result, result.status == ST_MATCH)
  `RTFM_ASSERT_IMP(a_other_is_last, result_valid && result.status != ST_MATCH, result.last_result)
  // a read always goes through the row store, so the intake closes behind it
  `RTFM_ASSERT_NXT(a_read_busy, item_valid && item_ready && item.mode == MODE_READ, !item_ready)

endmodule

`default_nettype wire
